// ===== rtl/leb_pkg.sv =====
package leb_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_ERASE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KILL  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_EOL   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_END   = 2'd3;

  localparam logic [CharW-1:0] ERASE_RST   = 8'd35;
  localparam logic [CharW-1:0] KILL_RST    = 8'd64;
  localparam logic [CharW-1:0] EOL_RST     = 8'd10;
  localparam logic [CharW-1:0] END_RST     = 8'd36;
  localparam logic [CharW-1:0] NEWLINE_CHR = 8'd10;

  typedef struct packed {
    logic append;
    logic erase;
    logic kill;
    logic start;
    logic rd_en;
    logic load_char;
    logic load_nl;
  } leb_cmd_t;

  typedef struct packed {
    logic line_end;
    logic is_fin;
    logic is_erase;
    logic is_kill;
    logic empty;
    logic full;
    logic last_char;
    logic out_free;
    logic fin;
  } leb_status_t;

endpackage

// ===== rtl/leb_dpath.sv =====
module leb_dpath import leb_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CharW-1:0]     cfg_data_i,
  input  logic [CharW-1:0]     in_char_i,
  input  leb_cmd_t             cmd_i,
  output leb_status_t          status_o,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [CharW-1:0]     m_tdata_o,
  output logic                 m_tlast_o,
  output logic                 m_tuser_o
);

  localparam int unsigned CntW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IdxW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [CharW-1:0] erase_q, kill_q, eol_q, end_q;
  logic [CharW-1:0] store_q [LINE_DEPTH];
  logic [CharW-1:0] rd_data_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  rd_idx_inc;
  logic             fin_q;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;
  logic             out_fin_q;
  logic             out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= ERASE_RST;
      kill_q  <= KILL_RST;
      eol_q   <= EOL_RST;
      end_q   <= END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ERASE: erase_q <= cfg_data_i;
        REG_KILL:  kill_q  <= cfg_data_i;
        REG_EOL:   eol_q   <= cfg_data_i;
        REG_END:   end_q   <= cfg_data_i;
        default:   erase_q <= erase_q;
      endcase
    end
  end

  assign rd_idx_inc = rd_idx_q + 1'b1;
  assign out_free   = !out_valid_q || m_tready_i;

  always_comb begin
    status_o           = '0;
    status_o.is_fin    = (in_char_i == end_q);
    status_o.line_end  = (in_char_i == eol_q) || status_o.is_fin;
    status_o.is_erase  = (in_char_i == erase_q);
    status_o.is_kill   = (in_char_i == kill_q);
    status_o.empty     = (fill_q == '0);
    status_o.full      = (fill_q == CntW'(LINE_DEPTH));
    status_o.last_char = (rd_idx_inc == fill_q);
    status_o.out_free  = out_free;
    status_o.fin       = fin_q;
  end

  always_comb begin
    fill_d = fill_q;
    priority if (cmd_i.load_nl || cmd_i.kill) begin
      fill_d = '0;
    end else if (cmd_i.erase) begin
      fill_d = fill_q - 1'b1;
    end else if (cmd_i.append) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.start) begin
      rd_idx_d = '0;
    end else if (cmd_i.load_char) begin
      rd_idx_d = rd_idx_inc;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_char || cmd_i.load_nl) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_idx_q    <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.start) begin
        fin_q <= status_o.is_fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      store_q[fill_q[IdxW-1:0]] <= in_char_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= store_q[rd_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      out_char_q <= rd_data_q;
      out_last_q <= 1'b0;
      out_fin_q  <= fin_q;
    end else if (cmd_i.load_nl) begin
      out_char_q <= NEWLINE_CHR;
      out_last_q <= 1'b1;
      out_fin_q  <= fin_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_char_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_fin_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_char || cmd_i.load_nl) |-> out_free)
    else $error("output register overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(LINE_DEPTH))
    else $error("line fill exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (rd_idx_q < fill_q))
    else $error("read beyond stored line");

endmodule

// ===== rtl/leb_ctrl.sv =====
module leb_ctrl import leb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  leb_status_t status_i,
  output leb_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SH   = 3'd2;
  localparam logic [2:0] ST_NL   = 3'd3;
  localparam logic [2:0] ST_STOP = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign s_tready_o = (state_q == ST_IDLE) || (state_q == ST_STOP);
  assign accept     = s_tvalid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (status_i.line_end) begin
            cmd_o.start = 1'b1;
            state_d     = status_i.empty ? ST_NL : ST_RD;
          end else if (status_i.is_erase) begin
            cmd_o.erase = !status_i.empty;
          end else if (status_i.is_kill) begin
            cmd_o.kill = 1'b1;
          end else begin
            cmd_o.append = !status_i.full;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SH;
      end
      ST_SH: begin
        if (status_i.out_free) begin
          cmd_o.load_char = 1'b1;
          state_d         = status_i.last_char ? ST_NL : ST_RD;
        end
      end
      ST_NL: begin
        if (status_i.out_free) begin
          cmd_o.load_nl = 1'b1;
          state_d       = status_i.fin ? ST_STOP : ST_IDLE;
        end
      end
      ST_STOP: begin
        state_d = ST_STOP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.rd_en, cmd_o.load_char, cmd_o.load_nl,
              cmd_o.append, cmd_o.erase, cmd_o.kill}))
    else $error("conflicting datapath commands");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_nl && status_i.fin) |=> (state_q == ST_STOP))
    else $error("final line did not stop input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == ST_SH))
    else $error("read data not consumed");

endmodule

// ===== rtl/line_edit_buffer_unit.sv =====
// Line edit buffer: collects typed characters into a line of up to
// LINE_DEPTH characters and emits the edited line on a line end.
// Input stream (s_axis_*): one character per item in tdata[7:0].
// Output stream (m_axis_*): one emitted character per item in tdata[7:0];
// tlast marks the closing newline, tuser flags a line closed by the
// end character. Configuration port (cfg_*): register 0 erase, 1 kill,
// 2 end of line, 3 end; write only while the block is idle.
// Erase, kill and ordinary characters give no item. On a line end, each
// stored character is read from the registered line store and then loaded
// into the output register, and the closing newline follows; input is not
// taken until the newline is loaded. The single-entry output register holds
// an item while the receiver stalls; emission waits on it, and ordinary
// input flows once it holds the newline. Reset empties the line, restores
// the default codes and clears the stopped condition; after the end
// character, input items are accepted and dropped until reset.
module line_edit_buffer_unit import leb_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CharW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [CharW-1:0]   s_axis_tdata,  // [7:0] in_char
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [CharW-1:0]   m_axis_tdata,  // [7:0] out_char
  output logic               m_axis_tlast,
  output logic               m_axis_tuser   // [0] final_line
);

  leb_cmd_t    cmd;
  leb_status_t status;

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  leb_dpath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_char_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

// ===== test/line_edit_buffer_unit_tb.sv =====
`timescale 1ns / 100ps

module line_edit_buffer_unit_tb;
  import leb_pkg::*;

  localparam int unsigned LINE_DEPTH = 63;

  typedef struct packed {
    logic             fin;
    logic             last;
    logic [CharW-1:0] chr;
  } line_out_t;

  class line_scoreboard;
    logic [CharW-1:0] erase_c = ERASE_RST;
    logic [CharW-1:0] kill_c  = KILL_RST;
    logic [CharW-1:0] eol_c   = EOL_RST;
    logic [CharW-1:0] end_c   = END_RST;
    logic [CharW-1:0] line_q[$];
    line_out_t        emit_q[$];
    bit               halted = 1'b0;
    int               fails = 0;
    int               items = 0;
    int               lines = 0;
    int               results = 0;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CharW-1:0] val);
      case (idx)
        REG_ERASE: erase_c = val;
        REG_KILL:  kill_c = val;
        REG_EOL:   eol_c = val;
        REG_END:   end_c = val;
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      if (fails < 10) $display("%0t: %s", $realtime, msg);
      fails++;
    endfunction

    function int pending();
      return emit_q.size();
    endfunction

    function void note_char(logic [CharW-1:0] c);
      line_out_t r;
      items++;
      if (halted) return;
      if (c == eol_c || c == end_c) begin
        r.fin = (c == end_c);
        r.last = 1'b0;
        foreach (line_q[i]) begin
          r.chr = line_q[i];
          emit_q.push_back(r);
        end
        r.last = 1'b1;
        r.chr = NEWLINE_CHR;
        emit_q.push_back(r);
        line_q.delete();
        lines++;
        halted = r.fin;
      end else if (c == erase_c) begin
        if (line_q.size() > 0) void'(line_q.pop_back());
      end else if (c == kill_c) begin
        line_q.delete();
      end else if (line_q.size() < LINE_DEPTH) begin
        line_q.push_back(c);
      end
    endfunction

    function void check_out(logic [CharW-1:0] chr, logic last, logic fin);
      line_out_t exp_r;
      results++;
      if (emit_q.size() == 0) begin
        flag($sformatf("unexpected item chr=%h last=%b fin=%b", chr, last, fin));
        return;
      end
      exp_r = emit_q.pop_front();
      if (exp_r.chr !== chr || exp_r.last !== last || exp_r.fin !== fin)
        flag($sformatf("item %0d: expected chr=%h last=%b fin=%b, got chr=%h last=%b fin=%b",
                       results, exp_r.chr, exp_r.last, exp_r.fin, chr, last, fin));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CharW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [CharW-1:0]   s_axis_tdata = '0;  // [7:0] in_char
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [CharW-1:0]   m_axis_tdata;       // [7:0] out_char
  logic               m_axis_tlast;
  logic               m_axis_tuser;       // [0] final_line

  line_scoreboard sb = new();
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int items_sent = 0;

  line_edit_buffer_unit #(.LINE_DEPTH(LINE_DEPTH)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_out(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_char(s_axis_tdata);
    end
  end

  task automatic push_char(input logic [CharW-1:0] c);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CharW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_setting(input logic [CharW-1:0] e, k, l, d);
    wait_drain();
    repeat (4) @(posedge clk_i);
    write_reg(REG_ERASE, e);
    write_reg(REG_KILL, k);
    write_reg(REG_EOL, l);
    write_reg(REG_END, d);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CharW-1:0] any_char();
    logic [CharW-1:0] c;
    do c = CharW'($urandom); while (c == sb.end_c);
    return c;
  endfunction

  task automatic type_line(input int len, input int edit_pct, input bit close);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < edit_pct) push_char(sb.erase_c);
      else if (r < edit_pct + edit_pct / 3) push_char(sb.kill_c);
      else push_char(any_char());
    end
    if (close) push_char(sb.eol_c);
  endtask

  logic [CharW-1:0] opening [13] = '{8'h61, 8'h62, ERASE_RST, KILL_RST, ERASE_RST, 8'h78,
                                     EOL_RST, EOL_RST, 8'h00, 8'hFF, 8'h7F, 8'h80, EOL_RST};
  logic [CharW-1:0] settings [4][4] = '{'{8'h00, 8'hFF, 8'h0D, 8'h04},
                                        '{8'hFF, 8'h00, 8'h80, 8'h7F},
                                        '{8'h55, 8'h55, 8'hAA, 8'h01},
                                        '{8'h33, 8'h44, 8'h33, 8'hFE}};
  logic [CharW-1:0] closing [8] = '{8'h4F, 8'h4B, EOL_RST, 8'h61, ERASE_RST, KILL_RST,
                                    END_RST, 8'hFF};

  initial begin
    int chunk_start;
    int r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) push_char(opening[i]);

    for (int s = 0; s < 4; s++) begin
      write_setting(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
          default: begin src_idle_pct = 33; snk_stall_pct = 33; end
        endcase
        chunk_start = items_sent;
        while (items_sent - chunk_start < 18) begin
          r = $urandom_range(99);
          if (r < 5) type_line($urandom_range(60, 72), 0, 1'b1);
          else if (r < 15) type_line($urandom_range(1, 8), 20, 1'b0);
          else type_line($urandom_range(0, 12), 12, 1'b1);
          if ($urandom_range(14) == 0) wait_drain();
        end
      end
    end

    // end code shared with the line end code: the final line wins
    write_setting(ERASE_RST, KILL_RST, EOL_RST, EOL_RST);
    src_idle_pct = 33;
    snk_stall_pct = 33;
    foreach (closing[i]) push_char(closing[i]);
    wait_drain();
    repeat (20) @(posedge clk_i);

    if (sb.pending() != 0) sb.flag($sformatf("%0d items never arrived", sb.pending()));
    $display("Run covered %0d input items, %0d closed lines and %0d output items",
             sb.items, sb.lines, sb.results);
    $display("over six register settings, four idle mixes and input after stop; %0d errors",
             sb.fails);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
